[hdl/keypad_matrix_change_reporter_assert.svh]
// ---------------------------------------------------------------------------
// keypad_matrix_change_reporter_assert.svh
// Assertion macros used by the keypad change reporter top level.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_CHANGE_REPORTER_ASSERT_SVH
`define KEYPAD_MATRIX_CHANGE_REPORTER_ASSERT_SVH

// same-cycle implication
`define KMCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KMCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/kmcr_pkg.sv]
// ---------------------------------------------------------------------------
// kmcr_pkg
// Types and constants shared by the keypad change reporter.
// ---------------------------------------------------------------------------
package kmcr_pkg;

   // snapshot fields
   localparam int PCOUNT_W     = 5;
   localparam int SINGLE_W     = 4;
   localparam int COL_BYTE_W   = 8;
   localparam int NUM_COL_BYTES = 8;

   // tdata layout of a request item
   localparam int PCOUNT_LSB   = 0;
   localparam int SROW_LSB     = PCOUNT_LSB + PCOUNT_W;
   localparam int SCOL_LSB     = SROW_LSB + SINGLE_W;
   localparam int COLS_LSB     = SCOL_LSB + SINGLE_W;
   localparam int REQ_USED_W   = COLS_LSB + NUM_COL_BYTES * COL_BYTE_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // result
   localparam int SCAN_CODE_W  = 6;
   localparam int RSP_TDATA_W  = 8;

   // configuration port
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COL_COUNT = 1'd1;

   // controller -> datapath
   typedef struct packed {
      logic load;    // take a new snapshot, restart the walk
      logic step;    // advance the walk by one key position
      logic finish;  // flush pending event, commit map
   } kmcr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_empty;  // row or column count is zero
      logic walk_last;   // walk sits on its final position
      logic can_step;
      logic can_finish;
      logic pend_valid;
   } kmcr_status_type;

endpackage

[hdl/kmcr_ctrl.sv]
// ---------------------------------------------------------------------------
// kmcr_ctrl
// Sequencer: accept snapshot, walk key positions, flush and commit.
// ---------------------------------------------------------------------------
module kmcr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     irq,
   output logic                     req_tready,
   input  kmcr_pkg::kmcr_status_type status,
   output kmcr_pkg::kmcr_cmd_type    cmd
);
   import kmcr_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (irq) begin
                  state_in = status.walk_empty ? ST_FINISH : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.step = status.can_step;
            if (status.can_step && status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = status.can_finish;
            if (status.can_finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/kmcr_datapath.sv]
// ---------------------------------------------------------------------------
// kmcr_datapath
// Key maps, walk counters, pending event and output register.
// ---------------------------------------------------------------------------
module kmcr_datapath #(
   parameter int MAX_COLS = 8,
   parameter int MAX_ROWS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kmcr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kmcr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [kmcr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  kmcr_pkg::kmcr_cmd_type            cmd,
   output kmcr_pkg::kmcr_status_type         status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kmcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import kmcr_pkg::*;

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [CSR_DATA_W-1:0] row_count_ff, col_count_ff;
   logic [CSR_DATA_W-1:0] rows_eff, cols_eff;
   logic [1:0]            shift;

   logic [MAX_COLS-1:0][MAX_ROWS-1:0] map_ff, fresh_ff, fresh_in;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;

   logic                   pend_valid_ff;
   logic [SCAN_CODE_W-1:0] pend_code_ff;
   logic                   pend_down_ff;

   logic                   out_valid_ff;
   logic [SCAN_CODE_W-1:0] out_code_ff;
   logic                   out_down_ff, out_last_ff;

   logic [PCOUNT_W-1:0] pcount;
   logic [SINGLE_W-1:0] srow, scol;
   logic hit, cur_down, row_end, col_end, can_out;
   logic [SCAN_CODE_W-1:0] cur_code;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CSR_DATA_W'(MAX_ROWS);
         col_count_ff <= CSR_DATA_W'(MAX_COLS);
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_ff <= csr_wdata;
            REG_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rows_eff = (row_count_ff > CSR_DATA_W'(MAX_ROWS)) ? CSR_DATA_W'(MAX_ROWS)
                                                          : row_count_ff;
   assign cols_eff = (col_count_ff > CSR_DATA_W'(MAX_COLS)) ? CSR_DATA_W'(MAX_COLS)
                                                          : col_count_ff;

   // ceil(log2(cols)), valid for cols up to 8
   always_comb begin
      if (cols_eff <= 4'd1)      shift = 2'd0;
      else if (cols_eff <= 4'd2) shift = 2'd1;
      else if (cols_eff <= 4'd4) shift = 2'd2;
      else                       shift = 2'd3;
   end

   // ---- new map from snapshot ----
   assign pcount = req_tdata[PCOUNT_LSB +: PCOUNT_W];
   assign srow   = req_tdata[SROW_LSB +: SINGLE_W];
   assign scol   = req_tdata[SCOL_LSB +: SINGLE_W];

   always_comb begin
      fresh_in = '0;
      if (pcount == PCOUNT_W'(1)) begin
         if (srow < SINGLE_W'(MAX_ROWS) && scol < SINGLE_W'(MAX_COLS)) begin
            fresh_in[scol[CW-1:0]][srow[RW-1:0]] = 1'b1;
         end
      end else if (pcount > PCOUNT_W'(1)) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            fresh_in[c] = req_tdata[COLS_LSB + c*COL_BYTE_W +: MAX_ROWS];
         end
      end
   end

   // ---- walk position ----
   assign hit      = map_ff[col_ff][row_ff] ^ fresh_ff[col_ff][row_ff];
   assign cur_down = fresh_ff[col_ff][row_ff];
   assign cur_code = (SCAN_CODE_W'(row_ff) << shift) + SCAN_CODE_W'(col_ff);
   assign row_end  = (CSR_DATA_W'(row_ff) + 4'd1) == rows_eff;
   assign col_end  = (CSR_DATA_W'(col_ff) + 4'd1) == cols_eff;
   assign can_out  = !out_valid_ff || rsp_tready;

   assign status.walk_empty = (rows_eff == '0) || (cols_eff == '0);
   assign status.walk_last  = row_end && col_end;
   assign status.can_step   = !hit || !pend_valid_ff || can_out;
   assign status.can_finish = !pend_valid_ff || can_out;
   assign status.pend_valid = pend_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fresh_ff <= fresh_in;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (cmd.step) begin
         if (row_end) begin
            row_ff <= '0;
            col_ff <= col_ff + CW'(1);
         end else begin
            row_ff <= row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else if (cmd.finish) begin
         map_ff <= fresh_ff;
      end
   end

   // ---- pending event: held one position back to know which is last ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.step && hit) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.finish) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && hit) begin
         pend_code_ff <= cur_code;
         pend_down_ff <= cur_down;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.step && hit && pend_valid_ff) || (cmd.finish && pend_valid_ff)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.step && hit && pend_valid_ff) || (cmd.finish && pend_valid_ff)) begin
         out_code_ff <= pend_code_ff;
         out_down_ff <= pend_down_ff;
         out_last_ff <= cmd.finish;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_code_ff);
   assign rsp_tuser  = out_down_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[hdl/keypad_matrix_change_reporter.sv]
// ---------------------------------------------------------------------------
// keypad_matrix_change_reporter
// Compares each keypad scan snapshot that has irq set with the stored key map
// and emits one item per changed key, columns ascending, rows ascending within a column.
// ---------------------------------------------------------------------------
//
// channel | dir | handshake         | payload
// --------+-----+-------------------+-------------------------------------
// req     | in  | tvalid / tready   | tdata: snapshot fields, tuser: irq
// rsp     | out | tvalid / tready   | tdata: scan code, tuser: key down,
//         |     |                   | tlast: final item of a snapshot
// csr     | in  | we (no wait)      | index, wdata: row/col count
//
// Sequence: a snapshot with irq low is only accepted. Otherwise an accept
//   step, then a walk over each key position (rows * cols, at most 64) at
//   one position per cycle unless an rsp stall holds it, then a flush/commit step.
// Each event is held one position back, so the final one is known and
//   tagged with tlast at the flush.
// Reset (synchronous): map all released, counts at MAX_ROWS / MAX_COLS.
// rsp stalls hold the walk only when a new changed key finds both the
//   pending slot and the output register full; the flush waits while an
//   event is pending and the output register is full.
//
module keypad_matrix_change_reporter #(
   parameter int MAX_COLS = 8,
   parameter int MAX_ROWS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // config write port
   input  logic                              csr_we,
   input  logic [kmcr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kmcr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // snapshot items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pressed_count[4:0], single_row[8:5], single_col[12:9],
   // col0_bits..col7_bits[76:13], zero pad[79:77]
   input  logic [kmcr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // matrix_irq[0]
   input  logic [0:0]                        req_tuser,
   // key change items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scan_code[5:0], zero pad[7:6]
   output logic [kmcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // key_down[0]
   output logic [0:0]                        rsp_tuser,
   // last_event
   output logic                              rsp_tlast
);
   import kmcr_pkg::*;

   kmcr_cmd_type    cmd;
   kmcr_status_type status;

   kmcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .irq        (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kmcr_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser[0]),
      .rsp_tlast  (rsp_tlast)
   );

   // ---- assertions ----
`include "keypad_matrix_change_reporter_assert.svh"

   // ignored snapshot leaves the block ready for the next one
   `KMCR_ASSERT_NEXT(a_irq_low_idle, clock, reset, req_tvalid && req_tready && !req_tuser[0], req_tready, "irq-low snapshot did not return to idle")
   // walk only advances when the pending/output path has room
   `KMCR_ASSERT_IMP(a_step_room, clock, reset, cmd.step, status.can_step, "walk advanced into a full event path")
   // no event is left pending once the block is idle again
   `KMCR_ASSERT_IMP(a_idle_no_pend, clock, reset, req_tready, !status.pend_valid, "pending event left behind at idle")

endmodule
